/* rtl/ads_pkg.sv */
// ----------------------------------------------------------------------------
// ads_pkg
// shared types, widths, register codes and helpers of the diffuse shader
// ----------------------------------------------------------------------------
package ads_pkg;

    localparam int COLOUR_BITS = 16;
    localparam logic [COLOUR_BITS-1:0] CMAX = {COLOUR_BITS{1'b1}};
    localparam logic [COLOUR_BITS-1:0] CHALF = CMAX >> 1;

    localparam int LV_W  = 49;   // light vector, signed Q18.30 range
    localparam int MAG_W = 48;   // magnitude of the light vector
    localparam int NRM_W = 30;   // normalized magnitude
    localparam int SUM_W = 62;   // sum of squares
    localparam int LEN_W = 31;   // integer square root
    localparam int Q_W   = 15;   // unit component magnitude, up to 16384
    localparam int NUM_W = 45;   // divider numerator
    localparam int SQ_STAGES  = 32;
    localparam int DIV_STAGES = Q_W + 1;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AMB_RATIO = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AMB_RED   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AMB_GREEN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_AMB_BLUE  = 3'd6;

    typedef struct packed {
        logic               in_shadow;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic        [31:0] hit_distance;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic        [15:0] base_red;
        logic        [15:0] base_green;
        logic        [15:0] base_blue;
    } ads_in_t;

    typedef struct packed {
        logic [15:0] shaded_red;
        logic [15:0] shaded_green;
        logic [15:0] shaded_blue;
    } ads_out_t;

    // data that rides along the pipeline beside the math
    typedef struct packed {
        logic                                shadow;
        logic                                zero;
        logic [2:0]                          neg;
        logic [2:0][NRM_W-1:0]               mag;
        logic [2:0][15:0]                    normal;
        logic [2:0][COLOUR_BITS-1:0]         base;
    } ads_side_t;

    // x / CMAX for x below CMAX*CMAX + CMAX, rounding already added
    function automatic logic [COLOUR_BITS-1:0] div_cmax(input logic [2*COLOUR_BITS-1:0] x);
        logic [COLOUR_BITS-1:0] q0;
        logic [COLOUR_BITS:0]   r;
        q0 = x[2*COLOUR_BITS-1:COLOUR_BITS];
        r  = {1'b0, x[COLOUR_BITS-1:0]} + {1'b0, q0};
        if (r >= {1'b0, CMAX})
            div_cmax = q0 + 1'b1;
        else
            div_cmax = q0;
    endfunction

endpackage

/* rtl/ads_light_vec.sv */
// ----------------------------------------------------------------------------
// ads_light_vec
// hit point, light vector, block normalization and sum of squares
// ----------------------------------------------------------------------------
module ads_light_vec (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              item_valid,
    input  ads_pkg::ads_in_t                  item,
    input  logic signed [31:0]                light_x,
    input  logic signed [31:0]                light_y,
    input  logic signed [31:0]                light_z,
    output logic                              out_valid,
    output logic [ads_pkg::SUM_W-1:0]         out_sum,
    output ads_pkg::ads_side_t                out_side
);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic signed [ads_pkg::LV_W-1:0] prod_reg [3];
    logic signed [ads_pkg::LV_W-1:0] lp_reg [3];
    logic        [ads_pkg::MAG_W-1:0] mag2_reg [3];
    logic        [ads_pkg::MAG_W-1:0] mag3_reg [3];
    logic        [5:0] msb_reg;
    logic        [2*ads_pkg::NRM_W-1:0] sq_reg [3];
    logic        [ads_pkg::SUM_W-1:0] sum_reg;
    ads_pkg::ads_side_t side1_reg, side2_reg, side3_reg, side4_reg, side5_reg, side6_reg;

    logic signed [15:0] dir_c [3];
    logic signed [31:0] lpos_c [3];
    logic signed [ads_pkg::LV_W-1:0] prod_c [3];
    logic signed [ads_pkg::LV_W-1:0] lv_c [3];
    logic signed [ads_pkg::LV_W-1:0] nlv_c [3];
    logic [ads_pkg::MAG_W-1:0] or_c;
    logic [5:0] msb_c;
    logic [ads_pkg::MAG_W-1:0] sh_c [3];
    ads_pkg::ads_side_t side1_c, side2_c, side3_c, side4_c;

    assign dir_c[0]  = item.dir_x;
    assign dir_c[1]  = item.dir_y;
    assign dir_c[2]  = item.dir_z;
    assign lpos_c[0] = light_x;
    assign lpos_c[1] = light_y;
    assign lpos_c[2] = light_z;

    always_comb
    begin
        side1_c           = '0;
        side1_c.shadow    = item.in_shadow;
        side1_c.normal[0] = item.normal_x;
        side1_c.normal[1] = item.normal_y;
        side1_c.normal[2] = item.normal_z;
        side1_c.base[0]   = item.base_red[ads_pkg::COLOUR_BITS-1:0];
        side1_c.base[1]   = item.base_green[ads_pkg::COLOUR_BITS-1:0];
        side1_c.base[2]   = item.base_blue[ads_pkg::COLOUR_BITS-1:0];
        side2_c           = side1_reg;
        for (int i = 0; i < 3; i++)
        begin
            prod_c[i] = $signed(dir_c[i]) * $signed({1'b0, item.hit_distance});
            lv_c[i]   = lp_reg[i] - prod_reg[i];
            nlv_c[i]  = -lv_c[i];
            side2_c.neg[i] = lv_c[i][ads_pkg::LV_W-1];
        end
        side3_c      = side2_reg;
        side3_c.zero = (mag2_reg[0] | mag2_reg[1] | mag2_reg[2]) == '0;
        or_c  = mag2_reg[0] | mag2_reg[1] | mag2_reg[2];
        msb_c = '0;
        for (int i = 0; i < ads_pkg::MAG_W; i++)
        begin
            if (or_c[i])
                msb_c = 6'(i);
        end
        side4_c = side3_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (msb_reg > 6'd29)
                sh_c[i] = mag3_reg[i] >> (msb_reg - 6'd29);
            else
                sh_c[i] = mag3_reg[i] << (6'd29 - msb_reg);
            side4_c.mag[i] = sh_c[i][ads_pkg::NRM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= item_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage 1: products and light position in Q18.30
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= prod_c[i];
                lp_reg[i]   <= {{3{lpos_c[i][31]}}, lpos_c[i], 14'b0};
            end
            side1_reg <= side1_c;
            // stage 2: difference, sign and magnitude
            side2_reg <= side2_c;
            for (int i = 0; i < 3; i++)
            begin
                if (lv_c[i][ads_pkg::LV_W-1])
                    mag2_reg[i] <= nlv_c[i][ads_pkg::MAG_W-1:0];
                else
                    mag2_reg[i] <= lv_c[i][ads_pkg::MAG_W-1:0];
            end
            // stage 3: leading one of the largest magnitude
            side3_reg <= side3_c;
            for (int i = 0; i < 3; i++)
                mag3_reg[i] <= mag2_reg[i];
            msb_reg <= msb_c;
            // stage 4: shift the largest into [2^29, 2^30)
            side4_reg <= side4_c;
            // stage 5: squares
            side5_reg <= side4_reg;
            for (int i = 0; i < 3; i++)
                sq_reg[i] <= side4_reg.mag[i] * side4_reg.mag[i];
            // stage 6: sum of squares
            side6_reg <= side5_reg;
            sum_reg   <= ads_pkg::SUM_W'(sq_reg[0]) + ads_pkg::SUM_W'(sq_reg[1])
                       + ads_pkg::SUM_W'(sq_reg[2]);
        end
    end

    assign out_valid = v6_reg;
    assign out_sum   = sum_reg;
    assign out_side  = side6_reg;

endmodule

/* rtl/ads_isqrt.sv */
// ----------------------------------------------------------------------------
// ads_isqrt
// floor integer square root, one result bit per pipeline stage
// ----------------------------------------------------------------------------
module ads_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [ads_pkg::SUM_W-1:0]     in_sum,
    input  ads_pkg::ads_side_t            in_side,
    output logic                          out_valid,
    output logic [ads_pkg::LEN_W-1:0]     out_len,
    output ads_pkg::ads_side_t            out_side
);

    localparam int N = ads_pkg::SQ_STAGES;
    localparam int W = ads_pkg::SUM_W + 1;

    logic               v_reg    [N];
    logic [W-1:0]       x_reg    [N];
    logic [W-1:0]       r_reg    [N];
    ads_pkg::ads_side_t side_reg [N];

    for (genvar k = 0; k < N; k++)
    begin : g_step
        logic               v_in;
        logic [W-1:0]       x_in;
        logic [W-1:0]       r_in;
        logic [W-1:0]       trial;
        ads_pkg::ads_side_t s_in;

        if (k == 0)
        begin : g_first
            assign v_in = in_valid;
            assign x_in = {1'b0, in_sum};
            assign r_in = '0;
            assign s_in = in_side;
        end
        else
        begin : g_next
            assign v_in = v_reg[k-1];
            assign x_in = x_reg[k-1];
            assign r_in = r_reg[k-1];
            assign s_in = side_reg[k-1];
        end

        assign trial = r_in + (W'(1) << (W - 1 - 2*k));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (adv)
                v_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                side_reg[k] <= s_in;
                if (x_in >= trial)
                begin
                    x_reg[k] <= x_in - trial;
                    r_reg[k] <= (r_in >> 1) + (W'(1) << (W - 1 - 2*k));
                end
                else
                begin
                    x_reg[k] <= x_in;
                    r_reg[k] <= r_in >> 1;
                end
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_len   = r_reg[N-1][ads_pkg::LEN_W-1:0];
    assign out_side  = side_reg[N-1];

endmodule

/* rtl/ads_divider.sv */
// ----------------------------------------------------------------------------
// ads_divider
// unit components: mag*16384/len rounded, restoring division on three lanes
// ----------------------------------------------------------------------------
module ads_divider (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              in_valid,
    input  logic [ads_pkg::LEN_W-1:0]         in_len,
    input  ads_pkg::ads_side_t                in_side,
    output logic                              out_valid,
    output logic [2:0][ads_pkg::Q_W-1:0]      out_unit,
    output ads_pkg::ads_side_t                out_side
);

    localparam int N  = ads_pkg::DIV_STAGES;
    localparam int NW = ads_pkg::NUM_W;
    localparam int QW = ads_pkg::Q_W;

    logic                      v_reg    [N];
    logic [ads_pkg::LEN_W-1:0] len_reg  [N];
    logic [2:0][NW-1:0]        rem_reg  [N];
    logic [2:0][QW-1:0]        q_reg    [N];
    ads_pkg::ads_side_t        side_reg [N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (adv)
            v_reg[0] <= in_valid;
    end

    // numerator with the rounding half of the divisor
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= in_side;
            len_reg[0]  <= in_len;
            q_reg[0]    <= '0;
            for (int i = 0; i < 3; i++)
                rem_reg[0][i] <= {1'b0, in_side.mag[i], 14'b0} + NW'(in_len >> 1);
        end
    end

    for (genvar s = 1; s < N; s++)
    begin : g_step
        logic [NW-1:0] dvs;

        assign dvs = NW'(len_reg[s-1]) << (N - 1 - s);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s] <= 1'b0;
            else if (adv)
                v_reg[s] <= v_reg[s-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                side_reg[s] <= side_reg[s-1];
                len_reg[s]  <= len_reg[s-1];
                for (int i = 0; i < 3; i++)
                begin
                    if (rem_reg[s-1][i] >= dvs)
                    begin
                        rem_reg[s][i] <= rem_reg[s-1][i] - dvs;
                        q_reg[s][i]   <= q_reg[s-1][i] | (QW'(1) << (N - 1 - s));
                    end
                    else
                    begin
                        rem_reg[s][i] <= rem_reg[s-1][i];
                        q_reg[s][i]   <= q_reg[s-1][i];
                    end
                end
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_unit  = q_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

/* rtl/ads_colour.sv */
// ----------------------------------------------------------------------------
// ads_colour
// dot product, intensity and ambient plus diffuse colour mix
// ----------------------------------------------------------------------------
module ads_colour (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic                                in_valid,
    input  logic [2:0][ads_pkg::Q_W-1:0]        in_unit,
    input  ads_pkg::ads_side_t                  in_side,
    input  logic [ads_pkg::COLOUR_BITS-1:0]     amb_ratio,
    input  logic [2:0][ads_pkg::COLOUR_BITS-1:0] amb_colour,
    output logic                                out_valid,
    output ads_pkg::ads_out_t                   out_item
);

    localparam int CB = ads_pkg::COLOUR_BITS;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic                      lit1_reg, lit2_reg;
    logic [2:0][CB-1:0]        base1_reg, base2_reg, base3_reg;
    logic signed [31:0]        dp_reg  [3];
    logic [2*CB-1:0]           tp_reg  [3];
    logic signed [33:0]        dot_reg;
    logic [2*CB-1:0]           tx_reg  [3];
    logic [CB-1:0]             t_reg   [3];
    logic [16:0]               int_reg;
    logic [2*CB-1:0]           ap_reg  [3];
    logic [2*CB-1:0]           ax_reg  [3];
    logic [CB+16:0]            dfp_reg [3];
    logic [CB-1:0]             a_reg   [3];
    logic [CB+2:0]             df_reg  [3];
    logic [CB+2:0]             df6_reg [3];
    logic [CB-1:0]             res_reg [3];

    logic signed [15:0] su_c [3];
    logic signed [31:0] dp_c [3];
    logic signed [33:0] dsum_c;
    logic [CB+3:0]      tot_c [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (in_side.neg[i])
                su_c[i] = -$signed({1'b0, in_unit[i]});
            else
                su_c[i] = $signed({1'b0, in_unit[i]});
            dp_c[i]  = su_c[i] * $signed(in_side.normal[i]);
            tot_c[i] = (CB+4)'(a_reg[i]) + (CB+4)'(df6_reg[i]);
        end
        dsum_c = dot_reg + 34'sd8192;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage 1: dot terms and base times ratio
            lit1_reg  <= !in_side.shadow && !in_side.zero;
            base1_reg <= in_side.base;
            for (int i = 0; i < 3; i++)
            begin
                dp_reg[i] <= dp_c[i];
                tp_reg[i] <= in_side.base[i] * amb_ratio;
            end
            // stage 2: dot sum, ambient rounding
            lit2_reg  <= lit1_reg;
            base2_reg <= base1_reg;
            dot_reg   <= 34'(dp_reg[0]) + 34'(dp_reg[1]) + 34'(dp_reg[2]);
            for (int i = 0; i < 3; i++)
                tx_reg[i] <= tp_reg[i] + (2*CB)'(ads_pkg::CHALF);
            // stage 3: intensity, first divide by full scale
            base3_reg <= base2_reg;
            if (lit2_reg && dot_reg > 34'sd0)
                int_reg <= dsum_c[30:14];
            else
                int_reg <= '0;
            for (int i = 0; i < 3; i++)
                t_reg[i] <= ads_pkg::div_cmax(tx_reg[i]);
            // stage 4: ambient colour and diffuse products
            for (int i = 0; i < 3; i++)
            begin
                ap_reg[i]  <= t_reg[i] * amb_colour[i];
                dfp_reg[i] <= base3_reg[i] * int_reg;
            end
            // stage 5: rounding terms
            for (int i = 0; i < 3; i++)
            begin
                ax_reg[i] <= ap_reg[i] + (2*CB)'(ads_pkg::CHALF);
                df_reg[i] <= (CB+3)'((dfp_reg[i] + (CB+17)'(8192)) >> 14);
            end
            // stage 6: ambient term, diffuse term waits beside it
            for (int i = 0; i < 3; i++)
            begin
                a_reg[i]   <= ads_pkg::div_cmax(ax_reg[i]);
                df6_reg[i] <= df_reg[i];
            end
            // stage 7: sum and saturation, output register
            for (int i = 0; i < 3; i++)
            begin
                if (tot_c[i] > (CB+4)'(ads_pkg::CMAX))
                    res_reg[i] <= ads_pkg::CMAX;
                else
                    res_reg[i] <= tot_c[i][CB-1:0];
            end
        end
    end

    assign out_valid              = v7_reg;
    assign out_item.shaded_red    = 16'(res_reg[0]);
    assign out_item.shaded_green  = 16'(res_reg[1]);
    assign out_item.shaded_blue   = 16'(res_reg[2]);

endmodule

/* rtl/ambient_diffuse_shader_core.sv */
// ----------------------------------------------------------------------------
// ambient_diffuse_shader_core
// lambert diffuse plus ambient shading of one ray hit, fully pipelined
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  hit       in         hit_valid / hit_ready     ads_in_t: shadow, ray, normal, base
//  shade     out        shade_valid / shade_ready ads_out_t: shaded rgb
//  cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
//  one item per cycle while the output is taken; the depth is set by the
//  square root (one bit a stage) and the unit vector divider (one bit a stage)
//  the whole pipeline holds when the output register is full and not taken,
//  so hit_ready is low in exactly those cycles
//  reset clears valid bits and config registers (ambient colour to full scale), no clearing pass
//  cfg writes are always taken, one per cycle
// ----------------------------------------------------------------------------
module ambient_diffuse_shader_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              hit_valid,
    output logic                              hit_ready,
    input  ads_pkg::ads_in_t                  hit,
    output logic                              shade_valid,
    input  logic                              shade_ready,
    output ads_pkg::ads_out_t                 shade,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ads_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                       cfg_data
);

    localparam int CB = ads_pkg::COLOUR_BITS;

    // config registers
    logic signed [31:0]  light_x_reg, light_y_reg, light_z_reg;
    logic [CB-1:0]       ratio_reg;
    logic [2:0][CB-1:0]  amb_reg;

    // global advance: every stage moves unless the result waits
    logic adv;

    logic                          lv_valid;
    logic [ads_pkg::SUM_W-1:0]     lv_sum;
    ads_pkg::ads_side_t            lv_side;
    logic                          sq_valid;
    logic [ads_pkg::LEN_W-1:0]     sq_len;
    ads_pkg::ads_side_t            sq_side;
    logic                          dv_valid;
    logic [2:0][ads_pkg::Q_W-1:0]  dv_unit;
    ads_pkg::ads_side_t            dv_side;

    assign adv       = !shade_valid || shade_ready;
    assign hit_ready = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_x_reg <= '0;
            light_y_reg <= '0;
            light_z_reg <= '0;
            ratio_reg   <= '0;
            amb_reg     <= {3{ads_pkg::CMAX}};
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ads_pkg::REG_LIGHT_X:   light_x_reg <= cfg_data;
                ads_pkg::REG_LIGHT_Y:   light_y_reg <= cfg_data;
                ads_pkg::REG_LIGHT_Z:   light_z_reg <= cfg_data;
                ads_pkg::REG_AMB_RATIO: ratio_reg   <= cfg_data[CB-1:0];
                ads_pkg::REG_AMB_RED:   amb_reg[0]  <= cfg_data[CB-1:0];
                ads_pkg::REG_AMB_GREEN: amb_reg[1]  <= cfg_data[CB-1:0];
                ads_pkg::REG_AMB_BLUE:  amb_reg[2]  <= cfg_data[CB-1:0];
                default:                ;  // unknown index, write dropped
            endcase
        end
    end

    // hit point, light vector, normalization, sum of squares
    ads_light_vec u_light_vec (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .item_valid (hit_valid && hit_ready),
        .item       (hit),
        .light_x    (light_x_reg),
        .light_y    (light_y_reg),
        .light_z    (light_z_reg),
        .out_valid  (lv_valid),
        .out_sum    (lv_sum),
        .out_side   (lv_side)
    );

    // vector length
    ads_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (lv_valid),
        .in_sum    (lv_sum),
        .in_side   (lv_side),
        .out_valid (sq_valid),
        .out_len   (sq_len),
        .out_side  (sq_side)
    );

    // unit light vector components
    ads_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sq_valid),
        .in_len    (sq_len),
        .in_side   (sq_side),
        .out_valid (dv_valid),
        .out_unit  (dv_unit),
        .out_side  (dv_side)
    );

    // intensity and colour mix, ends in the output register
    ads_colour u_colour (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (dv_valid),
        .in_unit    (dv_unit),
        .in_side    (dv_side),
        .amb_ratio  (ratio_reg),
        .amb_colour (amb_reg),
        .out_valid  (shade_valid),
        .out_item   (shade)
    );

endmodule

/* sim/tb_ambient_diffuse_shader_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ambient_diffuse_shader_core
// the testbench has its own model of the shader and predicts every shaded
// color. it drives hits and config writes, checks each result in order, and
// throttles the sender and receiver by phase, including one long back-pressure
// stretch
// ----------------------------------------------------------------------------
module tb_ambient_diffuse_shader_core;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LATENCY = 61;

    logic clk;
    logic rst_n;
    logic hit_valid;
    logic hit_ready;
    ads_pkg::ads_in_t hit;
    logic shade_valid;
    logic shade_ready;
    ads_pkg::ads_out_t shade;
    logic cfg_valid;
    logic cfg_ready;
    logic [ads_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    // model copy of the config registers
    logic signed [31:0] light_q [3];
    logic [15:0] amb_ratio_q;
    logic [15:0] amb_col_q [3];

    ads_pkg::ads_out_t expected_shades[$];
    int errors;
    int idle_cycles;
    int send_idle_pct;   // percent of cycles the sender stays idle
    int recv_stall_pct;  // percent of cycles the receiver stalls
    bit hold_off;        // receiver held off by the back-pressure process

    ambient_diffuse_shader_core u_top (
        .clk(clk), .rst_n(rst_n),
        .hit_valid(hit_valid), .hit_ready(hit_ready), .hit(hit),
        .shade_valid(shade_valid), .shade_ready(shade_ready), .shade(shade),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // floor integer square root, bit by bit
    function automatic logic [63:0] isqrt_floor(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] mdr(input logic [63:0] a, input logic [63:0] b,
                                        input logic [63:0] d);
        return (a * b + d / 2) / d;
    endfunction

    // lambert intensity in Q2.14 from light vector and normal
    function automatic logic [63:0] lambert_q14(input logic signed [63:0] lv [3],
                                                input logic signed [63:0] nv [3]);
        logic [63:0] mag [3];
        logic [63:0] m;
        logic [63:0] sum;
        logic [63:0] len;
        logic signed [63:0] u;
        logic signed [63:0] dot;
        bit neg [3];
        m = 0;
        sum = 0;
        dot = 0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = lv[i] < 0;
            mag[i] = neg[i] ? -lv[i] : lv[i];
            if (mag[i] > m)
                m = mag[i];
        end
        if (m == 0)
            return 0;
        while (m >= (64'd1 << 30))
        begin
            m = m >> 1;
            for (int i = 0; i < 3; i++)
                mag[i] = mag[i] >> 1;
        end
        while (m < (64'd1 << 29))
        begin
            m = m << 1;
            for (int i = 0; i < 3; i++)
                mag[i] = mag[i] << 1;
        end
        for (int i = 0; i < 3; i++)
            sum = sum + mag[i] * mag[i];
        len = isqrt_floor(sum);
        for (int i = 0; i < 3; i++)
        begin
            u = mdr(mag[i], 16384, len);
            if (neg[i])
                u = -u;
            dot = dot + u * nv[i];
        end
        if (dot <= 0)
            return 0;
        return (dot + 8192) >>> 14;
    endfunction

    function automatic ads_pkg::ads_out_t shade_hit(input ads_pkg::ads_in_t h);
        logic signed [63:0] lv [3];
        logic signed [63:0] nv [3];
        logic signed [63:0] dv [3];
        logic [15:0] base [3];
        logic [63:0] inten;
        logic [63:0] t;
        logic [63:0] r;
        logic [15:0] res [3];
        ads_pkg::ads_out_t o;
        dv[0] = h.dir_x; dv[1] = h.dir_y; dv[2] = h.dir_z;
        nv[0] = h.normal_x; nv[1] = h.normal_y; nv[2] = h.normal_z;
        base[0] = h.base_red; base[1] = h.base_green; base[2] = h.base_blue;
        for (int c = 0; c < 3; c++)
            lv[c] = $signed(light_q[c]) * 64'sd16384
                    - dv[c] * $signed({32'd0, h.hit_distance});
        inten = h.in_shadow ? 0 : lambert_q14(lv, nv);
        for (int c = 0; c < 3; c++)
        begin
            t = mdr(base[c], amb_ratio_q, 65535);
            r = mdr(t, amb_col_q[c], 65535);
            if (!h.in_shadow)
                r = r + mdr(base[c], inten, 16384);
            if (r > 65535)
                r = 65535;
            res[c] = r[15:0];
        end
        o.shaded_red = res[0];
        o.shaded_green = res[1];
        o.shaded_blue = res[2];
        return o;
    endfunction

    // drive one hit and wait for its acceptance; valid drops only in idle cycles
    task automatic send_hit(input ads_pkg::ads_in_t h);
        while ($urandom_range(99) < send_idle_pct)
        begin
            hit_valid <= 1'b0;
            @(posedge clk);
        end
        hit <= h;
        hit_valid <= 1'b1;
        @(posedge clk);
        while (!hit_ready)
            @(posedge clk);
        expected_shades.push_back(shade_hit(h));
    endtask

    // wait for the pipeline to empty, then some margin for late activity
    task automatic drain();
        hit_valid <= 1'b0;
        while (expected_shades.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ads_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] d);
        cfg_index <= idx;
        cfg_data <= d;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            ads_pkg::REG_LIGHT_X:   light_q[0] = d;
            ads_pkg::REG_LIGHT_Y:   light_q[1] = d;
            ads_pkg::REG_LIGHT_Z:   light_q[2] = d;
            ads_pkg::REG_AMB_RATIO: amb_ratio_q = d[15:0];
            ads_pkg::REG_AMB_RED:   amb_col_q[0] = d[15:0];
            ads_pkg::REG_AMB_GREEN: amb_col_q[1] = d[15:0];
            ads_pkg::REG_AMB_BLUE:  amb_col_q[2] = d[15:0];
            default: ;
        endcase
    endtask

    task automatic set_scene(input logic [31:0] lx, input logic [31:0] ly,
                             input logic [31:0] lz, input logic [15:0] ratio,
                             input logic [15:0] ar, input logic [15:0] ag,
                             input logic [15:0] ab);
        drain();
        write_reg(ads_pkg::REG_LIGHT_X, lx);
        write_reg(ads_pkg::REG_LIGHT_Y, ly);
        write_reg(ads_pkg::REG_LIGHT_Z, lz);
        write_reg(ads_pkg::REG_AMB_RATIO, {16'd0, ratio});
        write_reg(ads_pkg::REG_AMB_RED, {16'd0, ar});
        write_reg(ads_pkg::REG_AMB_GREEN, {16'd0, ag});
        write_reg(ads_pkg::REG_AMB_BLUE, {16'd0, ab});
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] rand_q14();
        return $signed(16'($urandom_range(32768))) - 16'sd16384;
    endfunction

    // random hit; mostly unit-range fields with small distances, some wild values
    function automatic ads_pkg::ads_in_t rand_hit();
        ads_pkg::ads_in_t h;
        h.in_shadow = $urandom_range(3) == 0;
        if ($urandom_range(9) < 8)
        begin
            h.dir_x = rand_q14(); h.dir_y = rand_q14(); h.dir_z = rand_q14();
            h.normal_x = rand_q14(); h.normal_y = rand_q14(); h.normal_z = rand_q14();
            h.hit_distance = $urandom_range(9) < 7 ? $urandom_range(32'h00200000) : $urandom;
        end
        else
        begin
            h.dir_x = 16'($urandom); h.dir_y = 16'($urandom); h.dir_z = 16'($urandom);
            h.normal_x = 16'($urandom); h.normal_y = 16'($urandom);
            h.normal_z = 16'($urandom);
            h.hit_distance = $urandom;
        end
        h.base_red = 16'($urandom); h.base_green = 16'($urandom);
        h.base_blue = 16'($urandom);
        return h;
    endfunction

    function automatic ads_pkg::ads_in_t make_hit(input bit sh,
                                         input logic signed [15:0] dx,
                                         input logic signed [15:0] dy,
                                         input logic signed [15:0] dz,
                                         input logic [31:0] hit_dist,
                                         input logic signed [15:0] nx,
                                         input logic signed [15:0] ny,
                                         input logic signed [15:0] nz,
                                         input logic [15:0] col);
        ads_pkg::ads_in_t h;
        h.in_shadow = sh;
        h.dir_x = dx; h.dir_y = dy; h.dir_z = dz;
        h.hit_distance = hit_dist;
        h.normal_x = nx; h.normal_y = ny; h.normal_z = nz;
        h.base_red = col; h.base_green = ~col; h.base_blue = col ^ 16'h5a5a;
        return h;
    endfunction

    // extremes of the fields, shadow, light at the hit point, non-unit vectors
    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_scene(32'h0001_0000, 32'h0002_0000, 32'hfffd_0000, 16'h4000,
                  16'hffff, 16'h8000, 16'h0000);
        send_hit(make_hit(0, 0, 0, 16384, 32'h0001_0000, 0, 0, -16384, 16'hffff));
        send_hit(make_hit(1, 0, 0, 16384, 32'h0001_0000, 0, 0, -16384, 16'hffff));
        send_hit(make_hit(0, 16384, 0, 0, 32'd0, 16384, 0, 0, 16'h0000));
        send_hit(make_hit(0, -16384, -16384, -16384, 32'hffff_ffff,
                          16384, 16384, 16384, 16'hffff));
        send_hit(make_hit(0, 16'sh7fff, 16'sh8000, 16'sh7fff, 32'hffff_ffff,
                          16'sh7fff, 16'sh7fff, 16'sh8000, 16'h1234));
        send_hit(make_hit(0, 0, 0, 0, 32'd0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'hffff));
        send_hit(make_hit(1, 16'sh8000, 16'sh8000, 16'sh8000, 32'hffff_ffff,
                          16'sh8000, 16'sh8000, 16'sh8000, 16'hffff));
        // light sits exactly on the hit point
        set_scene(32'h0001_0000, 32'd0, 32'd0, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_hit(make_hit(0, 16384, 0, 0, 32'h0001_0000, 16384, 0, 0, 16'h8000));
        send_hit(make_hit(0, 16384, 0, 0, 32'h0001_0000, -16384, 0, 0, 16'hffff));
        set_scene(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 16'h0000,
                  16'h0000, 16'h0000, 16'h0000);
        send_hit(make_hit(0, 16384, -16384, 0, 32'hffff_ffff, 16384, -16384, 16384, 16'hffff));
        send_hit(make_hit(1, 16384, -16384, 0, 32'hffff_ffff, 16384, -16384, 16384, 16'hffff));
        send_hit(make_hit(0, -16384, 16384, 0, 32'h0000_0001, 0, 0, 0, 16'h0001));
        send_hit(make_hit(0, 100, -200, 300, 32'h0100_0000, 16'sh8000, 0, 16'sh7fff, 16'h7fff));
    endtask

    // random hits under one idle pattern
    task automatic test_random(input int n, input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_stall_pct = r_pct;
        repeat (n) send_hit(rand_hit());
    endtask

    task automatic test_random_scene();
        set_scene($urandom_range(1) ? $urandom : $urandom_range(32'h0040_0000),
                  $urandom, $urandom_range(32'h0040_0000) - 32'h0020_0000,
                  16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // receiver held off long enough for the pipeline to fill and stall the input
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
        join_none
        repeat (150) send_hit(rand_hit());
    endtask

    // receiver: random stall per cycle
    always @(posedge clk)
    begin
        if (!rst_n)
            shade_ready <= 1'b0;
        else
            shade_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((hit_valid && hit_ready) || (shade_valid && shade_ready) || cfg_valid)
                idle_cycles <= 0;
            else if (expected_shades.size() != 0 || hit_valid)
                idle_cycles <= idle_cycles + 1;
            if (shade_valid && shade_ready)
            begin
                if (expected_shades.size() == 0)
                begin
                    $display("%0t unexpected shade %h", $time, shade);
                    errors++;
                end
                else
                begin
                    if (shade.shaded_red !== expected_shades[0].shaded_red)
                    begin
                        $display("%0t red exp %h got %h", $time,
                                 expected_shades[0].shaded_red, shade.shaded_red);
                        errors++;
                    end
                    if (shade.shaded_green !== expected_shades[0].shaded_green)
                    begin
                        $display("%0t green exp %h got %h", $time,
                                 expected_shades[0].shaded_green, shade.shaded_green);
                        errors++;
                    end
                    if (shade.shaded_blue !== expected_shades[0].shaded_blue)
                    begin
                        $display("%0t blue exp %h got %h", $time,
                                 expected_shades[0].shaded_blue, shade.shaded_blue);
                        errors++;
                    end
                    void'(expected_shades.pop_front());
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        errors = 0;
        idle_cycles = 0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        hit_valid = 1'b0;
        hit = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        for (int i = 0; i < 3; i++)
        begin
            light_q[i] = 0;
            amb_col_q[i] = 16'hffff;
        end
        amb_ratio_q = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // reset values first
        send_hit(make_hit(0, 0, 0, 16384, 32'h0002_0000, 0, 0, -16384, 16'h8000));
        test_directed();
        test_random_scene();
        test_random(200, 0, 0);
        test_random_scene();
        test_random(150, 73, 0);
        test_random_scene();
        test_random(150, 0, 73);
        test_random_scene();
        test_random(150, 20, 20);
        test_backpressure();
        drain();
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* ambient_diffuse_shader_core.f */
rtl/ads_pkg.sv
rtl/ads_light_vec.sv
rtl/ads_isqrt.sv
rtl/ads_divider.sv
rtl/ads_colour.sv
rtl/ambient_diffuse_shader_core.sv
sim/tb_ambient_diffuse_shader_core.sv
